// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset
`define BMG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included
`define BMG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/bmg_pkg.sv
// Shared types, constants and series tables for the Box-Muller generator.
// No dependencies.
package bmg_pkg;

   localparam int SAMPLE_BITS = 24;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   // u1 must be above this to be accepted (1e-7 floor)
   localparam sample_type FLOOR_K = sample_type'((1 << SAMPLE_BITS) / 10000000);

   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   localparam int          CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MEAN = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STD  = 1'd1;

   typedef struct packed {
      sample_type first;
      sample_type second;
   } job_type;

   typedef struct packed {
      logic signed [31:0] mean;
      logic signed [31:0] std_dev;
   } cfg_type;

   // Horner divisors for the cosine (to x^12) and sine (to x^11) series
   function automatic logic [7:0] series_div(input logic use_sin, input logic [2:0] idx);
      logic [7:0] d;
      d = 8'd2;
      if (use_sin) begin
         case (idx)
            3'd0: d = 8'd110;
            3'd1: d = 8'd72;
            3'd2: d = 8'd42;
            3'd3: d = 8'd20;
            default: d = 8'd6;
         endcase
      end else begin
         case (idx)
            3'd0: d = 8'd132;
            3'd1: d = 8'd90;
            3'd2: d = 8'd56;
            3'd3: d = 8'd30;
            3'd4: d = 8'd12;
            default: d = 8'd2;
         endcase
      end
      return d;
   endfunction

   // floor(2^32 / divisor), quotient may then be one short
   function automatic logic [31:0] series_recip(input logic use_sin, input logic [2:0] idx);
      logic [31:0] r;
      r = 32'd2147483648;
      if (use_sin) begin
         case (idx)
            3'd0: r = 32'd39045157;
            3'd1: r = 32'd59652323;
            3'd2: r = 32'd102261126;
            3'd3: r = 32'd214748364;
            default: r = 32'd715827882;
         endcase
      end else begin
         case (idx)
            3'd0: r = 32'd32537631;
            3'd1: r = 32'd47721858;
            3'd2: r = 32'd76695844;
            3'd3: r = 32'd143165576;
            3'd4: r = 32'd357913941;
            default: r = 32'd2147483648;
         endcase
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/bmg_front.sv
// Front end: pairs uniform samples, retries a too-small u1, queues jobs.
// Depends on bmg_pkg.
module bmg_front
   import bmg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_push,
   output logic       in_full,
   input  sample_type in_sample,
   output job_type    job_out,
   output logic       job_valid,
   input  logic       job_take
);

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_RETRY  = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   sample_type first_ff, first_in;
   sample_type second_ff, second_in;
   job_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       emit;
   job_type    new_job;

   assign in_full   = (count_ff == 2'd2);
   assign accept    = in_push && !in_full;
   assign job_valid = (count_ff != 2'd0);
   assign job_out   = queue_ff[rd_ptr_ff];

   // Classify the sample by pair phase
   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      emit      = 1'b0;
      new_job   = '{first: first_ff, second: in_sample};
      if (accept) begin
         unique case (phase_ff)
            PH_SECOND: begin
               second_in = in_sample;
               if (first_ff > FLOOR_K) begin
                  emit     = 1'b1;
                  phase_in = PH_FIRST;
               end else begin
                  phase_in = PH_RETRY;
               end
            end
            PH_RETRY: begin
               first_in = in_sample;
               new_job  = '{first: in_sample, second: second_ff};
               if (in_sample > FLOOR_K) begin
                  emit     = 1'b1;
                  phase_in = PH_FIRST;
               end
            end
            default: begin
               first_in = in_sample;
               phase_in = PH_SECOND;
            end
         endcase
      end
   end

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ emit;
      rd_ptr_in = rd_ptr_ff ^ job_take;
      count_in  = count_ff + {1'b0, emit} - {1'b0, job_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
      if (emit) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

// File: hw/rtl/bmg_back.sv
// Back end: sequencer around one shared 32x32 multiplier that evaluates
// the log, root, cosine and scaling of one job. Depends on bmg_pkg.
module bmg_back
   import bmg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  job_type            job_in,
   input  logic               job_valid,
   output logic               job_take,
   output logic               out_valid,
   input  logic               out_pop,
   output logic signed [31:0] out_value,
   output logic               out_sat
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG,
      ST_ROOT_T,
      ST_ROOT,
      ST_ANGLE,
      ST_SQUARE,
      ST_W,
      ST_QUO,
      ST_FIX,
      ST_SIN_TAIL,
      ST_RC,
      ST_MAG,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   sample_type         k2_ff, k2_in;
   logic [31:0]        m_ff, m_in;
   logic [29:0]        frac_ff, frac_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [4:0]         expo_ff, expo_in;
   logic [53:0]        n_ff, n_in;
   logic [53:0]        res_ff, res_in;
   logic [53:0]        bit_ff, bit_in;
   logic [26:0]        r_ff, r_in;
   logic               use_sin_ff, use_sin_in;
   logic               neg_ff, neg_in;
   logic [30:0]        a_ff, a_in;
   logic [30:0]        z_ff, z_in;
   logic [30:0]        h_ff, h_in;
   logic [30:0]        w_ff, w_in;
   logic [30:0]        q0_ff, q0_in;
   logic [2:0]         idx_ff, idx_in;
   logic [26:0]        rc_ff, rc_in;
   logic [33:0]        mag_ff, mag_in;
   logic               out_valid_ff, out_valid_in;
   logic signed [31:0] out_value_ff, out_value_in;
   logic               out_sat_ff, out_sat_in;

   logic [31:0] op_a, op_b;
   logic [63:0] prod;
   logic [4:0]  msb_pos;
   logic [31:0] smag;

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_sat   = out_sat_ff;

   // Shared multiplier
   assign prod = 64'(op_a) * 64'(op_b);

   assign smag = cfg.std_dev[31] ? (~cfg.std_dev + 32'd1) : cfg.std_dev;

   // Leading one of u1
   always_comb begin
      msb_pos = 5'd0;
      for (int i = 0; i < SAMPLE_BITS; i++) begin
         if (job_in.first[i]) begin
            msb_pos = 5'(i);
         end
      end
   end

   always_comb begin
      logic [31:0]        mm;
      logic [34:0]        lval;
      logic [53:0]        root_sum;
      logic [53:0]        res_next;
      logic [31:0]        ph;
      logic [29:0]        f;
      logic [29:0]        g;
      logic               f_low;
      logic [31:0]        rem;
      logic [30:0]        quo;
      logic [7:0]         dv;
      logic [2:0]         last_idx;
      logic signed [35:0] v;
      logic signed [35:0] total;

      state_in     = state_ff;
      k2_in        = k2_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      expo_in      = expo_ff;
      n_in         = n_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      r_in         = r_ff;
      use_sin_in   = use_sin_ff;
      neg_in       = neg_ff;
      a_in         = a_ff;
      z_in         = z_ff;
      h_in         = h_ff;
      w_in         = w_ff;
      q0_in        = q0_ff;
      idx_in       = idx_ff;
      rc_in        = rc_ff;
      mag_in       = mag_ff;
      out_value_in = out_value_ff;
      out_sat_in   = out_sat_ff;
      out_valid_in = out_valid_ff && !out_pop;
      job_take     = 1'b0;
      op_a         = 32'd0;
      op_b         = 32'd0;

      mm       = prod[61:30];
      lval     = {expo_ff, 30'd0} - {5'd0, frac_ff};
      root_sum = res_ff + bit_ff;
      res_next = res_ff >> 1;
      ph       = 32'(k2_ff) << (32 - SAMPLE_BITS);
      f        = ph[29:0];
      f_low    = ({1'b0, f} <= (Q30_ONE >> 1));
      g        = f_low ? f : 30'(Q30_ONE - {1'b0, f});
      dv       = series_div(use_sin_ff, idx_ff);
      rem      = 32'(w_ff) - prod[31:0];
      quo      = q0_ff + ((rem >= 32'(dv)) ? 31'd1 : 31'd0);
      last_idx = use_sin_ff ? 3'd4 : 3'd5;
      v        = neg_ff ? -$signed({2'b00, mag_ff}) : $signed({2'b00, mag_ff});
      total    = v + 36'(cfg.mean);

      unique case (state_ff)
         // Take a job, normalize u1 to Q1.30
         ST_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               m_in     = 32'(job_in.first) << (5'd30 - msb_pos);
               expo_in  = 5'(SAMPLE_BITS) - msb_pos;
               k2_in    = job_in.second;
               cnt_in   = 5'd29;
               frac_in  = 30'd0;
               state_in = ST_LOG;
            end
         end
         // One bit of log2 per squaring
         ST_LOG: begin
            op_a    = m_ff;
            op_b    = m_ff;
            m_in    = mm[31] ? {1'b0, mm[31:1]} : mm;
            frac_in = {frac_ff[28:0], mm[31]};
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_ROOT_T;
            end
         end
         // t = -2 ln u1 in Q.24, then set up the root
         ST_ROOT_T: begin
            op_a     = 32'(lval[34:6]);
            op_b     = 32'(TWO_LN2_Q30);
            n_in     = {prod[59:30], 24'd0};
            res_in   = 54'd0;
            bit_in   = 54'd1 << 52;
            state_in = ST_ROOT;
         end
         // Digit-by-digit square root
         ST_ROOT: begin
            if (n_ff >= root_sum) begin
               n_in     = n_ff - root_sum;
               res_next = (res_ff >> 1) + bit_ff;
            end
            res_in = res_next;
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               r_in     = res_next[26:0];
               state_in = ST_ANGLE;
            end
         end
         // Fold the phase into one octant, scale to radians
         ST_ANGLE: begin
            op_a       = 32'(g);
            op_b       = 32'(HALF_PI_Q30);
            a_in       = prod[60:30];
            use_sin_in = (f_low == ph[30]);
            neg_in     = (ph[31] ^ ph[30]) ^ cfg.std_dev[31];
            state_in   = ST_SQUARE;
         end
         ST_SQUARE: begin
            op_a     = 32'(a_ff);
            op_b     = 32'(a_ff);
            z_in     = prod[60:30];
            h_in     = Q30_ONE;
            idx_in   = 3'd0;
            state_in = ST_W;
         end
         // Horner step: product, reciprocal quotient, fix-up
         ST_W: begin
            op_a     = 32'(z_ff);
            op_b     = 32'(h_ff);
            w_in     = prod[60:30];
            state_in = ST_QUO;
         end
         ST_QUO: begin
            op_a     = 32'(w_ff);
            op_b     = series_recip(use_sin_ff, idx_ff);
            q0_in    = prod[62:32];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            op_a   = 32'(q0_ff);
            op_b   = 32'(dv);
            h_in   = Q30_ONE - quo;
            idx_in = idx_ff + 3'd1;
            if (idx_ff == last_idx) begin
               state_in = use_sin_ff ? ST_SIN_TAIL : ST_RC;
            end else begin
               state_in = ST_W;
            end
         end
         ST_SIN_TAIL: begin
            op_a     = 32'(a_ff);
            op_b     = 32'(h_ff);
            h_in     = prod[60:30];
            state_in = ST_RC;
         end
         ST_RC: begin
            op_a     = 32'(r_ff);
            op_b     = 32'(h_ff);
            rc_in    = prod[56:30];
            state_in = ST_MAG;
         end
         ST_MAG: begin
            op_a     = 32'(rc_ff);
            op_b     = smag;
            mag_in   = prod[57:24];
            state_in = ST_OUT;
         end
         // Add the mean, saturate, hold until the output slot frees
         ST_OUT: begin
            if (!out_valid_ff || out_pop) begin
               out_valid_in = 1'b1;
               if (total > 36'sd2147483647) begin
                  out_value_in = 32'sh7FFF_FFFF;
                  out_sat_in   = 1'b1;
               end else if (total < -36'sd2147483648) begin
                  out_value_in = 32'sh8000_0000;
                  out_sat_in   = 1'b1;
               end else begin
                  out_value_in = total[31:0];
                  out_sat_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      k2_ff        <= k2_in;
      m_ff         <= m_in;
      frac_ff      <= frac_in;
      cnt_ff       <= cnt_in;
      expo_ff      <= expo_in;
      n_ff         <= n_in;
      res_ff       <= res_in;
      bit_ff       <= bit_in;
      r_ff         <= r_in;
      use_sin_ff   <= use_sin_in;
      neg_ff       <= neg_in;
      a_ff         <= a_in;
      z_ff         <= z_in;
      h_ff         <= h_in;
      w_ff         <= w_in;
      q0_ff        <= q0_in;
      idx_ff       <= idx_in;
      rc_ff        <= rc_in;
      mag_ff       <= mag_in;
      out_value_ff <= out_value_in;
      out_sat_ff   <= out_sat_in;
   end

endmodule

// File: hw/rtl/box_muller_normal_generator_top.sv
// Top level of the Box-Muller normal generator: CSRs, front end, back end.
// Depends on bmg_pkg, bmg_front and bmg_back.
//
// Push 24-bit uniform samples in; every accepted pair (with u1 retried while
// it is at or below the 1e-7 floor) yields one signed Q15.16 variate,
// mean + std * sqrt(-2 ln u1) * cos(2 pi u2), saturated to 32 bits with a
// saturated flag. The back end works on one job at a time: 30 squaring rounds
// for the log on its single shared multiplier, a 27-step root and the Horner
// steps of the series. A two-entry job queue lets samples keep arriving
// meanwhile; req_full rises when it is full. Results wait in an output
// register until popped. CSR writes are always ready and should be made
// while no job is in flight.
module box_muller_normal_generator_top
   import bmg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [SAMPLE_BITS-1:0]  req_uniform_sample,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic signed [31:0]      rsp_normal_value,
   output logic                    rsp_saturated,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0]             csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   job_type job;
   logic    job_valid;
   logic    job_take;
   logic    out_valid;

   assign csr_ready = 1'b1;
   assign rsp_empty = !out_valid;

   // Decode CSR writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MEAN: cfg_in.mean    = csr_wdata;
            CSR_STD:  cfg_in.std_dev = csr_wdata;
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mean    <= 32'sd0;
         cfg_ff.std_dev <= 32'sd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_push   (req_push),
      .in_full   (req_full),
      .in_sample (req_uniform_sample),
      .job_out   (job),
      .job_valid (job_valid),
      .job_take  (job_take)
   );

   bmg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_in    (job),
      .job_valid (job_valid),
      .job_take  (job_take),
      .out_valid (out_valid),
      .out_pop   (rsp_pop),
      .out_value (rsp_normal_value),
      .out_sat   (rsp_saturated)
   );

endmodule

// File: hw/rtl/bmg_checker.sv
// Port-level checker for the Box-Muller generator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bmg_checker
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_empty,
   input logic                    rsp_pop,
   input logic signed [31:0]      rsp_normal_value,
   input logic                    rsp_saturated,
   input logic                    csr_ready
);

   // CSR channel never back-pressures
   `BMG_ASSERT_ALWAYS(a_csr_ready, csr_ready, "csr_ready dropped")

   // No stale result survives reset
   `BMG_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> rsp_empty, "result present after reset")

   // A waiting result holds until its transaction completes
   `BMG_ASSERT(a_rsp_hold, !rsp_empty && !rsp_pop |=> $stable(rsp_normal_value) && $stable(rsp_saturated), "result changed while waiting")

   // A clipped result sits at one of the rails
   `BMG_ASSERT(a_sat_rail, !rsp_empty && rsp_saturated |-> (rsp_normal_value == 32'sh7FFF_FFFF || rsp_normal_value == 32'sh8000_0000), "saturated flag off the rails")

endmodule

bind box_muller_normal_generator_top bmg_checker u_checker (.*);

// File: dv/box_muller_normal_generator_top_tb.sv
// Testbench for box_muller_normal_generator_top: directed, extreme-setting and random runs.
// Depends on bmg_pkg and the generator RTL. A local bit-exact predictor supplies expected
// variates, and a checker compares each popped result with them.
`timescale 1ns / 1ps

module box_muller_normal_generator_top_tb
   import bmg_pkg::*;
();

   typedef enum logic [1:0] {PAIR_FIRST, PAIR_SECOND, PAIR_RETRY} pair_phase_type;

   typedef struct {
      logic signed [31:0] value;
      logic               sat;
   } variate_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic [SAMPLE_BITS-1:0]  req_uniform_sample = '0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   logic signed [31:0]      rsp_normal_value;
   logic                    rsp_saturated;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [31:0]             csr_wdata = '0;

   // Predictor state and configuration copy
   pair_phase_type    gen_phase;
   sample_type        gen_u1, gen_u2;
   logic signed [31:0] gen_mean, gen_std;
   variate_type       pending_variates[$];

   int  errors = 0;
   int  samples_sent = 0;
   int  variates_seen = 0;
   int  saturations_seen = 0;
   bit  idle_on = 1'b1;
   bit  pop_taken = 1'b0;
   int  pop_wait = 0;

   box_muller_normal_generator_top i_dut (.*);

   always #4 clock = ~clock;

   // -log2(k / 2^24) in Q.30
   function automatic longint unsigned neg_log2_q30(sample_type k);
      int unsigned       p;
      longint unsigned   m, frac;
      p = 0;
      frac = 0;
      for (int b = 0; b < SAMPLE_BITS; b++)
         if (k[b]) p = b;
      m = longint'(k) << (30 - p);
      for (int i = 29; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac |= 64'd1 << i;
         end
      end
      return (longint'(SAMPLE_BITS - p) << 30) - frac;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Truncated Horner series on Q.30 radians: cosine to x^12 or sine to x^11
   function automatic longint unsigned series_q30(longint unsigned x, bit want_sin);
      int unsigned       cos_div[6] = '{132, 90, 56, 30, 12, 2};
      int unsigned       sin_div[5] = '{110, 72, 42, 20, 6};
      longint unsigned   z, h;
      z = (x * x) >> 30;
      h = 64'd1 << 30;
      for (int i = 0; i < (want_sin ? 5 : 6); i++)
         h = (64'd1 << 30) - ((z * h) >> 30) / (want_sin ? sin_div[i] : cos_div[i]);
      return want_sin ? (x * h) >> 30 : h;
   endfunction

   function automatic variate_type predict_variate(sample_type u1, sample_type u2,
                                                   logic signed [31:0] mean,
                                                   logic signed [31:0] sd);
      longint unsigned l24, t, r, ph, q, f, a, cs, sn, cmag, rc, smag, mag;
      bit              cneg, sneg;
      longint          sum;
      variate_type     v;
      l24 = neg_log2_q30(u1) >> 6;
      t = (l24 * TWO_LN2_Q30) >> 30;
      r = int_sqrt(t << 24);
      // Fold the phase onto the first octant
      ph = (longint'(u2) << (32 - SAMPLE_BITS)) & 64'hFFFF_FFFF;
      q = ph >> 30;
      f = ph & ((64'd1 << 30) - 1);
      if (f <= (64'd1 << 29)) begin
         a = (f * HALF_PI_Q30) >> 30;
         cs = series_q30(a, 1'b0);
         sn = series_q30(a, 1'b1);
      end else begin
         a = (((64'd1 << 30) - f) * HALF_PI_Q30) >> 30;
         cs = series_q30(a, 1'b1);
         sn = series_q30(a, 1'b0);
      end
      cneg = (q == 1 || q == 2);
      cmag = (q == 0 || q == 2) ? cs : sn;
      rc = (r * cmag) >> 30;
      sneg = sd < 0;
      smag = sneg ? longint'(-longint'(sd)) : longint'(sd);
      mag = (rc * smag) >> 24;
      sum = (cneg != sneg) ? -longint'(mag) : longint'(mag);
      sum = sum + longint'(mean);
      v.sat = 1'b0;
      if (sum > 64'sd2147483647) begin
         sum = 64'sd2147483647;
         v.sat = 1'b1;
      end else if (sum < -64'sd2147483648) begin
         sum = -64'sd2147483648;
         v.sat = 1'b1;
      end
      v.value = sum[31:0];
      return v;
   endfunction

   // Advance the pair state for one accepted sample
   function automatic void step_generator(sample_type k);
      case (gen_phase)
         PAIR_SECOND: begin
            gen_u2 = k;
            if (gen_u1 > FLOOR_K) begin
               gen_phase = PAIR_FIRST;
               pending_variates.push_back(predict_variate(gen_u1, gen_u2, gen_mean, gen_std));
            end else begin
               gen_phase = PAIR_RETRY;
            end
         end
         PAIR_RETRY: begin
            gen_u1 = k;
            if (k > FLOOR_K) begin
               gen_phase = PAIR_FIRST;
               pending_variates.push_back(predict_variate(gen_u1, gen_u2, gen_mean, gen_std));
            end
         end
         default: begin
            gen_u1 = k;
            gen_phase = PAIR_SECOND;
         end
      endcase
   endfunction

   // Push one sample; push stays high after the transaction for back-to-back use
   task automatic send_sample(sample_type k);
      int gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push = 1'b1;
      req_uniform_sample = k;
      do @(posedge clock); while (req_full);
      step_generator(k);
      samples_sent++;
   endtask

   // Hold until every expected variate has been popped, then let the back end settle
   task automatic drain_results();
      @(negedge clock);
      req_push = 1'b0;
      while (pending_variates.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] data);
      @(negedge clock);
      req_push = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MEAN) gen_mean = data;
      else if (idx == CSR_STD) gen_std = data;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(logic [31:0] mean, logic [31:0] sd);
      drain_results();
      write_csr(CSR_MEAN, mean);
      write_csr(CSR_STD, sd);
   endtask

   task automatic test_directed();
      // Retry of u1: zero and one fail the floor, two passes
      send_sample(24'd0);
      send_sample(24'd5);
      send_sample(24'd1);
      send_sample(24'd2);
      // Smallest passing u1 and the largest sample as u2
      send_sample(24'd2);
      send_sample(24'hFF_FFFF);
      send_sample(24'hFF_FFFF);
      send_sample(24'd0);
      // Quadrant starts and the octant fold boundary
      send_sample(24'h80_0000);
      send_sample(24'h40_0000);
      send_sample(24'hC0_0000);
      send_sample(24'h80_0000);
      send_sample(24'h12_3456);
      send_sample(24'h20_0000);
      send_sample(24'h12_3456);
      send_sample(24'h20_0001);
      send_sample(24'h00_0003);
      send_sample(24'hC0_0000);
      send_sample(24'h55_AAAA);
      send_sample(24'h60_0000);
      drain_results();
   endtask

   // Extreme settings, saturation in both directions included
   task automatic test_config_extremes();
      logic [31:0] means[6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                32'h0000_0000, 32'h7FFF_0000, 32'hFFFF_0000};
      logic [31:0] stds[6]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h0000_0000, 32'hFFFF_0000, 32'h0100_0000};
      for (int s = 0; s < 6; s++) begin
         set_config(means[s], stds[s]);
         for (int i = 0; i < 24; i++) send_sample(sample_type'($urandom));
         send_sample(24'd2);
         send_sample(24'd0);
      end
   endtask

   task automatic test_random_stream();
      sample_type k;
      for (int seg = 0; seg < 6; seg++) begin
         set_config($urandom, seg[0] ? $urandom_range(0, 32'h0008_0000) : $urandom);
         idle_on = (seg != 2);
         for (int i = 0; i < 300; i++) begin
            // Mostly clean pairs; a few samples near the floor force retries
            k = ($urandom_range(0, 15) == 0) ? sample_type'($urandom_range(0, 3))
                                             : sample_type'($urandom);
            send_sample(k);
            // Hold off the sender once until everything is out
            if (seg == 3 && i == 150) drain_results();
         end
      end
      idle_on = 1'b1;
      set_config(32'h0000_0000, 32'h0001_0000);
   endtask

   // Consumer stall: a fresh wait drawn after each popped transaction
   always @(negedge clock) begin
      if (pop_taken) begin
         pop_wait = idle_on ? $urandom_range(0, 6) : 0;
         pop_taken = 1'b0;
      end
      if (pop_wait > 0) begin
         rsp_pop <= 1'b0;
         pop_wait--;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Compare each popped result with the oldest expected variate
   always @(posedge clock) begin
      variate_type exp_v;
      if (!reset && rsp_pop && !rsp_empty) begin
         pop_taken = 1'b1;
         variates_seen++;
         if (rsp_saturated) saturations_seen++;
         if (pending_variates.size() == 0) begin
            $error("unexpected result: normal_value %0d saturated %0d",
                   rsp_normal_value, rsp_saturated);
            errors++;
         end else begin
            exp_v = pending_variates.pop_front();
            if (rsp_normal_value !== exp_v.value) begin
               $error("normal_value: expected %0d, actual %0d", exp_v.value, rsp_normal_value);
               errors++;
            end
            if (rsp_saturated !== exp_v.sat) begin
               $error("saturated: expected %0d, actual %0d", exp_v.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   initial begin
      gen_phase = PAIR_FIRST;
      gen_u1 = '0;
      gen_u2 = '0;
      gen_mean = 32'sd0;
      gen_std = 32'sd65536;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_config_extremes();
      test_random_stream();
      drain_results();
      if (pending_variates.size() != 0) errors++;
      $display("Sent %0d samples, checked %0d variates (%0d saturated) over 14 settings.",
               samples_sent, variates_seen, saturations_seen);
      if (errors == 0)
         $display("PASS box_muller_normal_generator_top");
      else
         $display("FAIL box_muller_normal_generator_top");
      $finish;
   end

   // Stop a hung run
   initial begin
      #20_000_000;
      $display("FAIL box_muller_normal_generator_top");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/bmg_pkg.sv
hw/rtl/bmg_front.sv
hw/rtl/bmg_back.sv
hw/rtl/box_muller_normal_generator_top.sv
hw/rtl/bmg_checker.sv
dv/box_muller_normal_generator_top_tb.sv
